FILE: rtl/core/aqi_pkg.sv
// ----------------------------------------------------------------------------
// aqi_pkg
// Shared types, constants and the sensor limit table of the air quality
// index aggregator.
// ----------------------------------------------------------------------------
package aqi_pkg;

   // payload widths
   localparam int IDX_W   = 4;
   localparam int READ_W  = 20;
   localparam int BAND_W  = 2;
   localparam int PCT_W   = 7;
   localparam int SCORE_W = 7;
   localparam int IBAND_W = 3;

   // limit and difference width, holds reading minus min without overflow
   localparam int LIM_W  = 21;
   // widest span between min and max of any table row
   localparam int SPAN_W = 19;

   // percent scale and score band thresholds
   localparam int PCT_FULL       = 100;
   localparam int TH_EXCELLENT   = 80;
   localparam int TH_GOOD        = 60;
   localparam int TH_MODERATE    = 40;
   localparam int TH_POOR        = 20;

   // per-sensor band
   typedef enum logic [BAND_W-1:0] {
      SB_GOOD,
      SB_MODERATE,
      SB_POOR,
      SB_DISCONNECTED
   } sband_type;

   // aggregate score band codes
   localparam logic [IBAND_W-1:0] IB_NO_DATA   = 3'd0;
   localparam logic [IBAND_W-1:0] IB_EXCELLENT = 3'd1;
   localparam logic [IBAND_W-1:0] IB_GOOD      = 3'd2;
   localparam logic [IBAND_W-1:0] IB_MODERATE  = 3'd3;
   localparam logic [IBAND_W-1:0] IB_POOR      = 3'd4;
   localparam logic [IBAND_W-1:0] IB_HAZARDOUS = 3'd5;

   // limits of one sensor, in hundredths
   typedef struct packed {
      logic signed [LIM_W-1:0] lo;
      logic signed [LIM_W-1:0] hi;
      logic signed [LIM_W-1:0] good;
      logic signed [LIM_W-1:0] warn;
   } limits_type;

   function automatic limits_type lim_row(input int lo, input int hi,
                                          input int good, input int warn);
      limits_type r;
      r.lo   = LIM_W'(lo);
      r.hi   = LIM_W'(hi);
      r.good = LIM_W'(good);
      r.warn = LIM_W'(warn);
      return r;
   endfunction

   // build-time limit table, spare rows share one generic entry
   function automatic limits_type aqi_limits(input logic [IDX_W-1:0] row);
      limits_type r;
      unique case (row)
         4'd0:    r = lim_row(40000, 500000, 100000, 200000);
         4'd1:    r = lim_row(0, 500000, 100000, 300000);
         4'd2:    r = lim_row(0, 50000, 10000, 25000);
         4'd3:    r = lim_row(0, 10000, 6000, 8000);
         4'd4:    r = lim_row(3200, 12000, 7700, 8600);
         4'd5:    r = lim_row(100, 100000, 3500, 20000);
         4'd6:    r = lim_row(5, 1000, 10, 50);
         4'd7:    r = lim_row(1000, 50000, 5000, 20000);
         4'd8:    r = lim_row(100, 100000, 5000, 30000);
         4'd9:    r = lim_row(100, 50000, 2500, 5000);
         4'd10:   r = lim_row(100000, 500000, 150000, 300000);
         default: r = lim_row(0, 10000, 5000, 7500);
      endcase
      return r;
   endfunction

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PCT,
      ST_PCT_WAIT,
      ST_SCAN,
      ST_NORM_WAIT,
      ST_AVG,
      ST_AVG_WAIT,
      ST_SCORE,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic pct_load;
      logic pct_save;
      logic scan_clear;
      logic norm_load;
      logic scan_step;
      logic avg_load;
      logic score_save;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pct_div;
      logic norm_div;
      logic last;
      logic count_zero;
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/core/aqi_req_if.sv
// ----------------------------------------------------------------------------
// aqi_req_if
// Sensor reading channel: valid, ready and one reading word.
// ----------------------------------------------------------------------------
interface aqi_req_if;
   import aqi_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         sensor_index;
   logic signed [READ_W-1:0] reading;
   logic                     present;

   modport source (output valid, output sensor_index, output reading,
                   output present, input ready);
   modport sink   (input valid, input sensor_index, input reading,
                   input present, output ready);
endinterface

FILE: rtl/core/aqi_rsp_if.sv
// ----------------------------------------------------------------------------
// aqi_rsp_if
// Result channel: valid, ready and one result word.
// ----------------------------------------------------------------------------
interface aqi_rsp_if;
   import aqi_pkg::*;

   logic               valid;
   logic               ready;
   logic               accepted;
   logic [BAND_W-1:0]  sensor_band;
   logic [PCT_W-1:0]   bar_percent;
   logic [SCORE_W-1:0] index_score;
   logic [IBAND_W-1:0] index_band;

   modport source (output valid, output accepted, output sensor_band,
                   output bar_percent, output index_score, output index_band,
                   input ready);
   modport sink   (input valid, input accepted, input sensor_band,
                   input bar_percent, input index_score, input index_band,
                   output ready);
endinterface

FILE: rtl/core/aqi_div.sv
// ----------------------------------------------------------------------------
// aqi_div
// Radix-2 restoring divider, one quotient bit per cycle. The caller loads a
// partial remainder below the divisor and the remaining dividend bits,
// left aligned; after the given number of steps the quotient sits in quo.
// ----------------------------------------------------------------------------
module aqi_div #(
   parameter int DEN_W = 19,
   parameter int Q_W   = 17,
   parameter int SW    = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DEN_W-1:0] rem0,
   input  logic [Q_W-1:0]   low,
   input  logic [DEN_W-1:0] den,
   input  logic [SW-1:0]    steps,
   output logic             busy,
   output logic [Q_W-1:0]   quo
);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [SW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // one trial subtraction
   always_comb begin
      trial = {rem_ff, q_ff[Q_W-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = trial >= {1'b0, den_ff};
   end

   // load or step
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = rem0;
         den_in  = den;
         q_in    = low;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         q_in    = {q_ff[Q_W-2:0], ge};
         cnt_in  = cnt_ff - SW'(1);
         busy_in = (cnt_ff != SW'(1));
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign busy = busy_ff;
   assign quo  = q_ff;

endmodule

FILE: rtl/core/aqi_dp.sv
// ----------------------------------------------------------------------------
// aqi_dp
// Datapath: sensor store, limit lookups, clamping, the shared divider, the
// running sum and count, the score and the result register.
// ----------------------------------------------------------------------------
module aqi_dp #(
   parameter int NUM_SENSORS = 11,
   parameter int FRAC_BITS   = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  aqi_pkg::cmd_type                 cmd,
   output aqi_pkg::status_type              stat,
   input  logic [aqi_pkg::IDX_W-1:0]        in_index,
   input  logic signed [aqi_pkg::READ_W-1:0] in_reading,
   input  logic                             in_present,
   input  logic                             rsp_ready,
   output logic                             out_valid,
   output logic                             out_accepted,
   output logic [aqi_pkg::BAND_W-1:0]       out_band,
   output logic [aqi_pkg::PCT_W-1:0]        out_percent,
   output logic [aqi_pkg::SCORE_W-1:0]      out_score,
   output logic [aqi_pkg::IBAND_W-1:0]      out_iband
);
   import aqi_pkg::*;

   localparam int IW     = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
   localparam int CNT_W  = $clog2(NUM_SENSORS + 1);
   localparam int Q_W    = FRAC_BITS + 1;
   localparam int SUM_W  = FRAC_BITS + 5;
   localparam int SW     = $clog2(Q_W + 1);
   localparam int PROD_W = SPAN_W + PCT_W;
   localparam int SC_W   = Q_W + PCT_W;
   localparam logic [IDX_W:0]   NUM_LIM = (IDX_W + 1)'(NUM_SENSORS);
   localparam logic [Q_W-1:0]   ONE_Q   = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(PCT_FULL);

   // item registers
   logic [IDX_W-1:0]         idx_ff;
   logic signed [READ_W-1:0] raw_ff;
   logic                     present_ff;

   // sensor store
   logic signed [READ_W-1:0] store_ff [NUM_SENSORS];
   logic [NUM_SENSORS-1:0]   flag_ff;

   // scan state
   logic [IW-1:0]    i_ff, i_in;
   logic [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0] cnt_ff;

   // per item results
   logic               accepted_ff;
   sband_type          band_ff;
   logic [PCT_W-1:0]   pct_ff;
   logic [SCORE_W-1:0] score_ff;
   logic [IBAND_W-1:0] iband_ff;

   // result register
   logic               out_valid_ff;
   logic               out_acc_ff;
   sband_type          out_band_ff;
   logic [PCT_W-1:0]   out_pct_ff;
   logic [SCORE_W-1:0] out_score_ff;
   logic [IBAND_W-1:0] out_iband_ff;

   // item side signals
   limits_type              lim_c;
   logic signed [LIM_W-1:0] v_c, d_c, span_c;
   logic                    in_range_c, item_ok_c, pct_div_c;
   logic [PROD_W-1:0]       prod_c;
   sband_type               band_c;
   logic [PCT_W-1:0]        pct_clamp_c;

   // scan side signals
   limits_type              lim_s;
   logic signed [LIM_W-1:0] v_s, d_s, span_s;
   logic                    flag_s, norm_div_c, last_c;
   logic [Q_W-1:0]          norm_clamp_c;

   // divider ports
   logic             div_start, div_busy;
   logic [SPAN_W-1:0] div_rem0, div_den;
   logic [Q_W-1:0]   div_low, div_quo;
   logic [SW-1:0]    div_steps;

   // score signals
   logic [Q_W-1:0]     inv_c;
   logic [SC_W-1:0]    sc_prod_c;
   logic [SCORE_W-1:0] score_c;
   logic [IBAND_W-1:0] iband_c;

   logic wr_en;

   // reading of the current item against its limits
   always_comb begin
      lim_c      = aqi_limits(idx_ff);
      v_c        = LIM_W'(raw_ff);
      d_c        = v_c - lim_c.lo;
      span_c     = lim_c.hi - lim_c.lo;
      in_range_c = {1'b0, idx_ff} < NUM_LIM;
      item_ok_c  = in_range_c && present_ff;
      pct_div_c  = item_ok_c && (d_c > 0) && (d_c < span_c);
      prod_c     = PROD_W'(d_c[SPAN_W-1:0]) * PROD_W'(PCT_FULL);
      if (!item_ok_c) begin
         band_c = SB_DISCONNECTED;
      end else if (v_c <= lim_c.good) begin
         band_c = SB_GOOD;
      end else if (v_c <= lim_c.warn) begin
         band_c = SB_MODERATE;
      end else begin
         band_c = SB_POOR;
      end
      if (!item_ok_c || d_c <= 0) begin
         pct_clamp_c = '0;
      end else begin
         pct_clamp_c = PCT_MAX;
      end
   end

   // stored sensor under the scan pointer
   always_comb begin
      lim_s      = aqi_limits(IDX_W'(i_ff));
      v_s        = LIM_W'(store_ff[i_ff]);
      d_s        = v_s - lim_s.lo;
      span_s     = lim_s.hi - lim_s.lo;
      flag_s     = flag_ff[i_ff];
      norm_div_c = flag_s && (d_s > 0) && (d_s < span_s);
      norm_clamp_c = (d_s <= 0) ? '0 : ONE_Q;
      last_c     = (i_ff == IW'(NUM_SENSORS - 1));
      i_in       = last_c ? '0 : i_ff + IW'(1);
   end

   // divider operand select
   always_comb begin
      div_start = cmd.pct_load || cmd.norm_load || cmd.avg_load;
      div_rem0  = SPAN_W'(d_s);
      div_low   = '0;
      div_den   = SPAN_W'(span_s);
      div_steps = SW'(FRAC_BITS);
      priority if (cmd.pct_load) begin
         div_rem0  = prod_c[PROD_W-1:PCT_W];
         div_low   = {prod_c[PCT_W-1:0], {(Q_W - PCT_W){1'b0}}};
         div_den   = SPAN_W'(span_c);
         div_steps = SW'(PCT_W);
      end else if (cmd.avg_load) begin
         div_rem0  = SPAN_W'(sum_ff[SUM_W-1:Q_W]);
         div_low   = sum_ff[Q_W-1:0];
         div_den   = SPAN_W'(cnt_ff);
         div_steps = SW'(Q_W);
      end else begin
         div_rem0  = SPAN_W'(d_s);
      end
   end

   aqi_div #(
      .DEN_W (SPAN_W),
      .Q_W   (Q_W),
      .SW    (SW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .rem0  (div_rem0),
      .low   (div_low),
      .den   (div_den),
      .steps (div_steps),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   // score from the mean
   always_comb begin
      inv_c     = ONE_Q - div_quo;
      sc_prod_c = SC_W'(inv_c) * SC_W'(PCT_FULL);
      if (cnt_ff == '0) begin
         score_c = '0;
      end else begin
         score_c = sc_prod_c[FRAC_BITS+SCORE_W-1:FRAC_BITS];
      end
      if (cnt_ff == '0) begin
         iband_c = IB_NO_DATA;
      end else if (score_c >= SCORE_W'(TH_EXCELLENT)) begin
         iband_c = IB_EXCELLENT;
      end else if (score_c >= SCORE_W'(TH_GOOD)) begin
         iband_c = IB_GOOD;
      end else if (score_c >= SCORE_W'(TH_MODERATE)) begin
         iband_c = IB_MODERATE;
      end else if (score_c >= SCORE_W'(TH_POOR)) begin
         iband_c = IB_POOR;
      end else begin
         iband_c = IB_HAZARDOUS;
      end
   end

   assign wr_en = cmd.capture && ({1'b0, in_index} < NUM_LIM);

   // connected flags
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= '0;
      end else if (wr_en) begin
         flag_ff[in_index[IW-1:0]] <= in_present;
      end
   end

   // stored readings, only read behind a set flag
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[in_index[IW-1:0]] <= in_reading;
      end
   end

   // item capture and per item results
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff     <= in_index;
         raw_ff     <= in_reading;
         present_ff <= in_present;
      end
      if (cmd.pct_save) begin
         accepted_ff <= in_range_c;
         band_ff     <= band_c;
         pct_ff      <= pct_div_c ? div_quo[PCT_W-1:0] : pct_clamp_c;
      end
      if (cmd.score_save) begin
         score_ff <= score_c;
         iband_ff <= iband_c;
      end
   end

   // scan pointer, sum and count
   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff   <= '0;
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.scan_clear) begin
         i_ff   <= '0;
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.scan_step) begin
         i_ff <= i_in;
         if (flag_s) begin
            sum_ff <= sum_ff + SUM_W'(norm_div_c ? div_quo : norm_clamp_c);
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // result register word
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_acc_ff   <= accepted_ff;
         out_band_ff  <= band_ff;
         out_pct_ff   <= pct_ff;
         out_score_ff <= score_ff;
         out_iband_ff <= iband_ff;
      end
   end

   // status back to the controller
   always_comb begin
      stat.pct_div    = pct_div_c;
      stat.norm_div   = norm_div_c;
      stat.last       = last_c;
      stat.count_zero = (cnt_ff == '0);
      stat.div_busy   = div_busy;
      stat.out_free   = !out_valid_ff || rsp_ready;
   end

   assign out_valid    = out_valid_ff;
   assign out_accepted = out_acc_ff;
   assign out_band     = BAND_W'(out_band_ff);
   assign out_percent  = out_pct_ff;
   assign out_score    = out_score_ff;
   assign out_iband    = out_iband_ff;

endmodule

FILE: rtl/core/aqi_ctrl.sv
// ----------------------------------------------------------------------------
// aqi_ctrl
// Controller: sequences capture, percent division, the scan over the stored
// sensors, the mean division, scoring and the hand-off to the result register.
// ----------------------------------------------------------------------------
module aqi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  aqi_pkg::status_type stat,
   output aqi_pkg::cmd_type    cmd
);
   import aqi_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PCT;
         end
         ST_PCT: begin
            state_in = stat.pct_div ? ST_PCT_WAIT : ST_SCAN;
         end
         ST_PCT_WAIT: begin
            if (!stat.div_busy) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.norm_div) begin
               state_in = ST_NORM_WAIT;
            end else if (stat.last) begin
               state_in = ST_AVG;
            end
         end
         ST_NORM_WAIT: begin
            if (!stat.div_busy) state_in = stat.last ? ST_AVG : ST_SCAN;
         end
         ST_AVG: begin
            state_in = stat.count_zero ? ST_SCORE : ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (!stat.div_busy) state_in = ST_SCORE;
         end
         ST_SCORE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_PCT: begin
            cmd.scan_clear = 1'b1;
            cmd.pct_load   = stat.pct_div;
            cmd.pct_save   = !stat.pct_div;
         end
         ST_PCT_WAIT: begin
            cmd.pct_save = !stat.div_busy;
         end
         ST_SCAN: begin
            cmd.norm_load = stat.norm_div;
            cmd.scan_step = !stat.norm_div;
         end
         ST_NORM_WAIT: begin
            cmd.scan_step = !stat.div_busy;
         end
         ST_AVG: begin
            cmd.avg_load = !stat.count_zero;
         end
         ST_AVG_WAIT: begin
         end
         ST_SCORE: begin
            cmd.score_save = 1'b1;
         end
         ST_EMIT: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/core/air_quality_index_aggregator_core.sv
// ----------------------------------------------------------------------------
// air_quality_index_aggregator_core
// Stores sensor readings and answers each with its band, its bar percent and
// the aggregate air quality score over all connected sensors.
// ----------------------------------------------------------------------------
// One reading word is taken at a time and answered by exactly one result
// word. An item passes through capture and limit checks, a division for the
// bar percent when it needs one, a scan over every stored sensor with a
// division for each connected sensor whose value lies strictly between its
// min and max, a division for the mean when any sensor is connected, and
// scoring and hand-off. Its length is set by the single shared radix-2
// divider, one quotient bit per cycle, used in turn for the percent, each
// normalized value and the mean. A new reading is taken while the previous
// result still waits in the output register. Index values at or above
// NUM_SENSORS are answered with accepted low and leave the store unchanged.
module air_quality_index_aggregator_core #(
   parameter int NUM_SENSORS = 11,
   parameter int FRAC_BITS   = 16
) (
   input logic      clock,
   input logic      reset,
   aqi_req_if.sink   req_bus,
   aqi_rsp_if.source rsp_bus
);
   import aqi_pkg::*;

   cmd_type    cmd;
   status_type stat;

   // control
   aqi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   aqi_dp #(
      .NUM_SENSORS (NUM_SENSORS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .in_index     (req_bus.sensor_index),
      .in_reading   (req_bus.reading),
      .in_present   (req_bus.present),
      .rsp_ready    (rsp_bus.ready),
      .out_valid    (rsp_bus.valid),
      .out_accepted (rsp_bus.accepted),
      .out_band     (rsp_bus.sensor_band),
      .out_percent  (rsp_bus.bar_percent),
      .out_score    (rsp_bus.index_score),
      .out_iband    (rsp_bus.index_band)
   );

`ifndef SYNTHESIS
   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("reading taken while another is in work");

   // rejected index answers as disconnected with an empty bar
   a_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.accepted) |->
      (rsp_bus.sensor_band == BAND_W'(SB_DISCONNECTED) && rsp_bus.bar_percent == '0))
      else $error("rejected reading with band or bar set");

   // no data means zero score
   a_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.index_band == IB_NO_DATA) |->
      (rsp_bus.index_score == '0))
      else $error("score present without data");

   // bar and score stay in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |->
      (rsp_bus.bar_percent <= PCT_W'(PCT_FULL) &&
       rsp_bus.index_score <= SCORE_W'(PCT_FULL)))
      else $error("bar or score above full scale");
`endif

endmodule

FILE: test/tb_air_quality_index_aggregator_core.sv
// ----------------------------------------------------------------------------
// tb_air_quality_index_aggregator_core
// Self-checking bench for the air quality index aggregator. A short table of
// readings covers index rejection, reading extremes and the band edges of sensor 6;
// random readings follow, biased toward the sensor ranges, with random gaps
// on the reading side and random stalls on the result side. Each result word is
// checked field by field against a fixed word or a local model of the sensor store.
// ----------------------------------------------------------------------------
module tb_air_quality_index_aggregator_core;
   import aqi_pkg::*;

   localparam int SENSORS      = 11;
   localparam int FRAC         = 16;
   localparam int RANDOM_ITEMS = 1680;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 256;
   localparam int MAX_REPORTS  = 10;

   // score band thresholds
   localparam int SCORE_EXCELLENT = 80;
   localparam int SCORE_GOOD      = 60;
   localparam int SCORE_MODERATE  = 40;
   localparam int SCORE_POOR      = 20;

   typedef struct packed {
      logic               accepted;
      sband_type          sensor_band;
      logic [PCT_W-1:0]   bar_percent;
      logic [SCORE_W-1:0] index_score;
      logic [IBAND_W-1:0] index_band;
   } result_word_type;

   typedef struct {
      logic [IDX_W-1:0] idx;
      int               rd;
      bit               pres;
      bit               typed;
      result_word_type  fixed;
   } stim_row_type;

   // sensor limits in hundredths: min, max, good, warn
   int lim_lo   [SENSORS] = '{40000, 0, 0, 0, 3200, 100, 5, 1000, 100, 100, 100000};
   int lim_hi   [SENSORS] = '{500000, 500000, 50000, 10000, 12000, 100000, 1000,
                              50000, 100000, 50000, 500000};
   int lim_good [SENSORS] = '{100000, 100000, 10000, 6000, 7700, 3500, 10, 5000,
                              5000, 2500, 150000};
   int lim_warn [SENSORS] = '{200000, 300000, 25000, 8000, 8600, 20000, 50, 20000,
                              30000, 5000, 300000};

   logic clock = 1'b0;
   logic reset = 1'b1;

   aqi_req_if req_bus ();
   aqi_rsp_if rsp_bus ();

   // local copy of the sensor store
   logic signed [READ_W-1:0] stored_reading [SENSORS];
   bit                       stored_present [SENSORS];

   result_word_type pending_results [$];
   stim_row_type    directed_rows [$];

   // tag of the word currently on the reading channel
   bit              drv_typed = 1'b0;
   result_word_type drv_fixed = '0;

   bit src_calm = 1'b0;
   int mismatches = 0;
   int results_seen = 0;
   int idle_cycles = 0;

   air_quality_index_aggregator_core #(
      .NUM_SENSORS (SENSORS),
      .FRAC_BITS   (FRAC)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // position of a reading between min and max, scaled, clamped to 0..scale
   function automatic longint unsigned scaled_position(input int sensor, input int value,
                                                       input longint unsigned scale);
      longint d;
      longint span;
      d    = longint'(value) - longint'(lim_lo[sensor]);
      span = longint'(lim_hi[sensor]) - longint'(lim_lo[sensor]);
      if (d <= 0) return 0;
      if (d >= span) return scale;
      return (longint'(d) * scale) / longint'(span);
   endfunction

   // update the store with one reading and work out its result word
   function automatic result_word_type predict_reading(input logic [IDX_W-1:0] idx,
                                                       input logic signed [READ_W-1:0] rd,
                                                       input logic pres);
      result_word_type r;
      longint unsigned one;
      longint unsigned sum;
      longint unsigned count;
      longint unsigned avg;
      longint unsigned s;
      int v;
      one = longint'(1) << FRAC;
      r   = '0;
      r.sensor_band = SB_DISCONNECTED;
      if (idx < SENSORS) begin
         stored_reading[idx] = rd;
         stored_present[idx] = pres;
         r.accepted = 1'b1;
         if (pres) begin
            v = rd;
            if (v <= lim_good[idx]) r.sensor_band = SB_GOOD;
            else if (v <= lim_warn[idx]) r.sensor_band = SB_MODERATE;
            else r.sensor_band = SB_POOR;
            r.bar_percent = PCT_W'(scaled_position(idx, v, 100));
         end
      end
      // aggregate over the connected sensors
      sum   = 0;
      count = 0;
      for (int i = 0; i < SENSORS; i++) begin
         if (stored_present[i]) begin
            sum   += scaled_position(i, int'(stored_reading[i]), one);
            count += 1;
         end
      end
      if (count == 0) begin
         r.index_score = '0;
         r.index_band  = IB_NO_DATA;
      end else begin
         avg = sum / count;
         s   = ((one - avg) * 100) >> FRAC;
         r.index_score = SCORE_W'(s);
         if (s >= SCORE_EXCELLENT) r.index_band = IB_EXCELLENT;
         else if (s >= SCORE_GOOD) r.index_band = IB_GOOD;
         else if (s >= SCORE_MODERATE) r.index_band = IB_MODERATE;
         else if (s >= SCORE_POOR) r.index_band = IB_POOR;
         else r.index_band = IB_HAZARDOUS;
      end
      return r;
   endfunction

   function automatic result_word_type result_of(input logic acc, input sband_type band,
                                                 input int pct, input int score,
                                                 input logic [IBAND_W-1:0] iband);
      result_word_type r;
      r.accepted    = acc;
      r.sensor_band = band;
      r.bar_percent = PCT_W'(pct);
      r.index_score = SCORE_W'(score);
      r.index_band  = iband;
      return r;
   endfunction

   // idle length: mostly short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // reading value, mostly around the target or the limits of the sensor
   function automatic int pick_reading(input int idx, input int target_pct);
      int mode;
      int lo;
      int span;
      int v;
      mode = $urandom_range(0, 99);
      if (idx >= SENSORS || mode >= 85) begin
         v = $urandom_range(0, 20'hFFFFF);
         return (v >= 32'h80000) ? v - 32'h100000 : v;
      end
      lo   = lim_lo[idx];
      span = lim_hi[idx] - lim_lo[idx];
      if (mode < 50) begin
         v = lo + (span / 100) * target_pct + int'($urandom_range(0, span / 10)) - span / 20;
      end else if (mode < 70) begin
         case ($urandom_range(0, 3))
            0:       v = lim_lo[idx];
            1:       v = lim_hi[idx];
            2:       v = lim_good[idx];
            default: v = lim_warn[idx];
         endcase
         v = v + int'($urandom_range(0, 4)) - 2;
      end else begin
         v = lo - span / 8 + int'($urandom_range(0, span + span / 4));
      end
      if (v > 524287) v = 524287;
      if (v < -524288) v = -524288;
      return v;
   endfunction

   task automatic add_row(input logic [IDX_W-1:0] idx, input int rd, input bit pres,
                          input bit typed, input result_word_type fixed);
      stim_row_type row;
      row.idx   = idx;
      row.rd    = rd;
      row.pres  = pres;
      row.typed = typed;
      row.fixed = fixed;
      directed_rows.push_back(row);
   endtask

   // put one reading word on the channel and hold it until taken
   task automatic send_reading(input logic [IDX_W-1:0] idx, input int rd, input bit pres,
                               input bit typed, input result_word_type fixed);
      int gap;
      gap = src_calm ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.sensor_index <= idx;
      req_bus.reading      <= READ_W'(rd);
      req_bus.present      <= pres;
      drv_typed            <= typed;
      drv_fixed            <= fixed;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // check result words, then predict newly taken readings
   always @(posedge clock) begin : watch_results
      result_word_type seen;
      result_word_type want;
      result_word_type pred;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.accepted    = rsp_bus.accepted;
            seen.sensor_band = sband_type'(rsp_bus.sensor_band);
            seen.bar_percent = rsp_bus.bar_percent;
            seen.index_score = rsp_bus.index_score;
            seen.index_band  = rsp_bus.index_band;
            if (pending_results.size() == 0) begin
               if (mismatches < MAX_REPORTS)
                  $display({"result %0d unexpected: acc=%0b band=%0d pct=%0d ",
                            "score=%0d iband=%0d"},
                           results_seen, seen.accepted, seen.sensor_band, seen.bar_percent,
                           seen.index_score, seen.index_band);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (seen.accepted !== want.accepted || seen.sensor_band !== want.sensor_band ||
                   seen.bar_percent !== want.bar_percent ||
                   seen.index_score !== want.index_score ||
                   seen.index_band !== want.index_band) begin
                  if (mismatches < MAX_REPORTS)
                     $display({"result %0d mismatch: expected acc=%0b band=%0d pct=%0d ",
                               "score=%0d iband=%0d, got acc=%0b band=%0d pct=%0d ",
                               "score=%0d iband=%0d"},
                              results_seen, want.accepted, want.sensor_band,
                              want.bar_percent, want.index_score, want.index_band,
                              seen.accepted, seen.sensor_band, seen.bar_percent,
                              seen.index_score, seen.index_band);
                  mismatches++;
               end
            end
            results_seen++;
         end
         if (req_bus.valid && req_bus.ready) begin
            pred = predict_reading(req_bus.sensor_index, req_bus.reading, req_bus.present);
            pending_results.push_back(drv_typed ? drv_fixed : pred);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side stalls, with calm stretches
   initial begin : result_sink
      int round;
      int on_len;
      int off_len;
      round = 0;
      rsp_bus.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         round++;
         on_len = $urandom_range(1, 12);
         @(negedge clock) rsp_bus.ready <= 1'b1;
         repeat (on_len - 1) @(negedge clock);
         off_len = (round % 40 < 8) ? 0 : pick_gap();
         if (off_len > 0) begin
            @(negedge clock) rsp_bus.ready <= 1'b0;
            repeat (off_len - 1) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [IDX_W-1:0] idx;
      int               rd;
      bit               pres;
      int               target_pct;
      int               pres_rate;
      stim_row_type     row;
      req_bus.valid        = 1'b0;
      req_bus.sensor_index = '0;
      req_bus.reading      = '0;
      req_bus.present      = 1'b0;
      for (int i = 0; i < SENSORS; i++) begin
         stored_reading[i] = '0;
         stored_present[i] = 1'b0;
      end

      // index rejection on an empty store, then extremes with a single sensor connected
      add_row(4'd15, 0, 1'b1, 1'b1, result_of(1'b0, SB_DISCONNECTED, 0, 0, IB_NO_DATA));
      add_row(4'd11, -524288, 1'b1, 1'b1,
              result_of(1'b0, SB_DISCONNECTED, 0, 0, IB_NO_DATA));
      add_row(4'd3, -524288, 1'b1, 1'b1, result_of(1'b1, SB_GOOD, 0, 100, IB_EXCELLENT));
      add_row(4'd3, 524287, 1'b1, 1'b1, result_of(1'b1, SB_POOR, 100, 0, IB_HAZARDOUS));
      add_row(4'd3, 524287, 1'b0, 1'b1,
              result_of(1'b1, SB_DISCONNECTED, 0, 0, IB_NO_DATA));
      add_row(4'd0, 40000, 1'b1, 1'b1, result_of(1'b1, SB_GOOD, 0, 100, IB_EXCELLENT));
      add_row(4'd0, 500000, 1'b1, 1'b1, result_of(1'b1, SB_POOR, 100, 0, IB_HAZARDOUS));
      // band edges at good and warn
      add_row(4'd6, 10, 1'b1, 1'b0, '0);
      add_row(4'd6, 11, 1'b1, 1'b0, '0);
      add_row(4'd6, 50, 1'b1, 1'b0, '0);
      add_row(4'd6, 51, 1'b1, 1'b0, '0);
      // fill the remaining sensors, sensor 9 below its min and the rest inside their ranges
      add_row(4'd1, 250000, 1'b1, 1'b0, '0);
      add_row(4'd2, 12345, 1'b1, 1'b0, '0);
      add_row(4'd4, 7700, 1'b1, 1'b0, '0);
      add_row(4'd5, 50000, 1'b1, 1'b0, '0);
      add_row(4'd7, 25000, 1'b1, 1'b0, '0);
      add_row(4'd8, 60000, 1'b1, 1'b0, '0);
      add_row(4'd9, 1, 1'b1, 1'b0, '0);
      add_row(4'd10, 300000, 1'b1, 1'b0, '0);
      add_row(4'd3, 6001, 1'b1, 1'b0, '0);
      // rejected index with stored data, negative and disconnected readings
      add_row(4'd13, 5000, 1'b0, 1'b0, '0);
      add_row(4'd10, -1, 1'b1, 1'b0, '0);
      add_row(4'd0, 524287, 1'b0, 1'b0, '0);
      add_row(4'd12, 5000, 1'b1, 1'b0, '0);

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         send_reading(row.idx, row.rd, row.pres, row.typed, row.fixed);
      end

      // random readings in epochs with a common target level and connect rate
      target_pct = 50;
      pres_rate  = 85;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) begin
            target_pct = $urandom_range(0, 100);
            case ($urandom_range(0, 2))
               0:       pres_rate = 30;
               1:       pres_rate = 85;
               default: pres_rate = 100;
            endcase
            src_calm = ($urandom_range(0, 4) == 0);
         end
         if ($urandom_range(0, 99) < 12) idx = IDX_W'($urandom_range(SENSORS, 15));
         else idx = IDX_W'($urandom_range(0, SENSORS - 1));
         pres = ($urandom_range(0, 99) < pres_rate);
         rd   = pick_reading(idx, target_pct);
         send_reading(idx, rd, pres, 1'b0, '0);
      end
      @(negedge clock) req_bus.valid <= 1'b0;

      // drain, then allow late words to show up
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: air_quality_index_aggregator_core.f
rtl/core/aqi_pkg.sv
rtl/core/aqi_req_if.sv
rtl/core/aqi_rsp_if.sv
rtl/core/aqi_div.sv
rtl/core/aqi_dp.sv
rtl/core/aqi_ctrl.sv
rtl/core/air_quality_index_aggregator_core.sv
test/tb_air_quality_index_aggregator_core.sv
